### sv/clkd_pkg.sv
// Shared types, codes and field widths of the caching lock directory.
package clkd_pkg;

   // Field widths fixed by the request and response formats
   localparam int LOCK_ID_W   = 6;
   localparam int CLIENT_W    = 4;
   localparam int STATUS_W    = 3;
   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam int LOCK_ID_SPAN = 1 << LOCK_ID_W;
   localparam int CLIENT_SPAN  = 1 << CLIENT_W;

   // Default sizing of the directory
   localparam int DEF_NUM_LOCKS   = 64;
   localparam int DEF_NUM_CLIENTS = 16;
   localparam int DEF_QUEUE_DEPTH = 16;

   typedef enum logic {
      CMD_ACQUIRE = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPLY  = 2'd0,
      KIND_REVOKE = 2'd1,
      KIND_RETRY  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_RETRY     = 3'd1,
      STAT_NOT_OWNER = 3'd2,
      STAT_ALREADY   = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP,
      BK_REPLY,
      BK_SECOND
   } back_state_type;

   // One classified request as it waits between front and back
   typedef struct packed {
      cmd_type               cmd;
      logic [LOCK_ID_W-1:0]  lock_id;
      logic [CLIENT_W-1:0]   client;
   } item_type;

   // Back end control seen by the front end
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;

endpackage

### sv/clkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/clkd_front.sv
// Front end: accept request beats, reduce lock and client indexes, queue them.
module clkd_front #(
   parameter int NUM_LOCKS   = clkd_pkg::DEF_NUM_LOCKS,
   parameter int NUM_CLIENTS = clkd_pkg::DEF_NUM_CLIENTS,
   localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [clkd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  clkd_pkg::back_ctrl_type             ctrl,
   output logic                                item_valid,
   output clkd_pkg::item_type                  item,
   output logic [LOCK_W-1:0]                   item_lock
);

   localparam int FIFO_DEPTH = 2;

   logic [LOCK_W-1:0]               lock_map   [clkd_pkg::LOCK_ID_SPAN];
   logic [clkd_pkg::CLIENT_W-1:0]   client_map [clkd_pkg::CLIENT_SPAN];

   clkd_pkg::item_type  entry_item_ff [FIFO_DEPTH];
   logic [LOCK_W-1:0]   entry_lock_ff [FIFO_DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;

   clkd_pkg::item_type  push_item;
   logic [clkd_pkg::LOCK_ID_W-1:0] in_lock;
   logic [clkd_pkg::CLIENT_W-1:0]  in_client;
   logic                push;

   // Constant index reduction tables
   for (genvar gi = 0; gi < clkd_pkg::LOCK_ID_SPAN; gi++) begin : g_lock_map
      assign lock_map[gi] = LOCK_W'(gi % NUM_LOCKS);
   end
   for (genvar gc = 0; gc < clkd_pkg::CLIENT_SPAN; gc++) begin : g_client_map
      assign client_map[gc] = clkd_pkg::CLIENT_W'(gc % NUM_CLIENTS);
   end

   assign in_lock   = req_tdata[clkd_pkg::LOCK_ID_W-1:0];
   assign in_client = req_tdata[clkd_pkg::LOCK_ID_W +: clkd_pkg::CLIENT_W];

   always_comb begin
      push_item.cmd     = clkd_pkg::cmd_type'(req_tuser);
      push_item.lock_id = in_lock;
      push_item.client  = client_map[in_client];
   end

   assign req_tready = (cnt_ff != 2'(FIFO_DEPTH)) && !ctrl.clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push     ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = ctrl.pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_item_ff[wr_ptr_ff] <= push_item;
         entry_lock_ff[wr_ptr_ff] <= lock_map[in_lock];
      end
   end

   assign item_valid = (cnt_ff != 2'd0);
   assign item       = entry_item_ff[rd_ptr_ff];
   assign item_lock  = entry_lock_ff[rd_ptr_ff];

endmodule

### sv/clkd_back.sv
// Back end: lock record read-modify-write, waiter queues and response beats.
module clkd_back #(
   parameter int NUM_LOCKS   = clkd_pkg::DEF_NUM_LOCKS,
   parameter int QUEUE_DEPTH = clkd_pkg::DEF_QUEUE_DEPTH,
   localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  clkd_pkg::item_type                item,
   input  logic [LOCK_W-1:0]                 item_lock,
   output clkd_pkg::back_ctrl_type           ctrl,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [clkd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [clkd_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W    = QIDX_W + 1;
   localparam int W_DEPTH  = NUM_LOCKS * QUEUE_DEPTH;
   localparam int WADDR_W  = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int CL_W     = clkd_pkg::CLIENT_W;
   localparam int PAD_W    = clkd_pkg::RSP_TDATA_W - clkd_pkg::STATUS_W - CL_W
                             - clkd_pkg::LOCK_ID_W;

   typedef struct packed {
      logic              owner_valid;
      logic [CL_W-1:0]   owner_client;
      logic              expected_valid;
      logic [CL_W-1:0]   expected_client;
      logic              revoke_sent;
      logic [QIDX_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   clkd_pkg::back_state_type state_ff, state_in;

   clkd_pkg::item_type   item_ff;
   logic [LOCK_W-1:0]    lock_ff;
   logic [LOCK_W-1:0]    clr_idx_ff, clr_idx_in;
   clkd_pkg::status_type st0_ff, st0_in;
   logic                 two_ff, two_in;
   clkd_pkg::kind_type   kind1_ff, kind1_in;
   logic [CL_W-1:0]      dest1_ff, dest1_in;
   logic                 patch_ff, patch_in;
   rec_type              patch_rec_ff;

   rec_type              rec, new_rec, patch_rec;
   logic [REC_W-1:0]     rec_rd_data;
   logic                 rec_we;
   logic [LOCK_W-1:0]    rec_waddr;
   logic [REC_W-1:0]     rec_wdata;

   logic                 wq_we, wq_re;
   logic [WADDR_W-1:0]   wq_waddr, wq_raddr, lock_base;
   logic [CL_W-1:0]      waiter_q;

   logic [SUM_W-1:0]     slot_sum;
   logic [QIDX_W-1:0]    slot, head_next;
   logic                 clr_last, beat_done, pop;
   logic [CL_W-1:0]      dest;
   clkd_pkg::status_type rsp_status;
   clkd_pkg::kind_type   rsp_kind;

   clkd_ram #(.WIDTH(REC_W), .DEPTH(NUM_LOCKS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_en   (pop),
      .rd_addr (item_lock),
      .rd_data (rec_rd_data)
   );

   clkd_ram #(.WIDTH(CL_W), .DEPTH(W_DEPTH)) u_waiter_ram (
      .clock   (clock),
      .wr_en   (wq_we),
      .wr_addr (wq_waddr),
      .wr_data (item_ff.client),
      .rd_en   (wq_re),
      .rd_addr (wq_raddr),
      .rd_data (waiter_q)
   );

   assign clr_last  = (clr_idx_ff == LOCK_W'(NUM_LOCKS - 1));
   assign beat_done = rsp_tvalid && rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clkd_pkg::BK_CLEAR: begin
            if (clr_last) state_in = clkd_pkg::BK_IDLE;
         end
         clkd_pkg::BK_IDLE: begin
            if (item_valid) state_in = clkd_pkg::BK_LOOKUP;
         end
         clkd_pkg::BK_LOOKUP: begin
            state_in = clkd_pkg::BK_REPLY;
         end
         clkd_pkg::BK_REPLY: begin
            if (rsp_tready) begin
               if (two_ff)          state_in = clkd_pkg::BK_SECOND;
               else if (item_valid) state_in = clkd_pkg::BK_LOOKUP;
               else                 state_in = clkd_pkg::BK_IDLE;
            end
         end
         clkd_pkg::BK_SECOND: begin
            if (rsp_tready) begin
               state_in = item_valid ? clkd_pkg::BK_LOOKUP : clkd_pkg::BK_IDLE;
            end
         end
         default: state_in = clkd_pkg::BK_CLEAR;
      endcase
   end

   // State outputs: beat presentation, pop of the next item
   always_comb begin
      rsp_tvalid = 1'b0;
      rsp_kind   = clkd_pkg::KIND_REPLY;
      rsp_status = st0_ff;
      dest       = item_ff.client;
      rsp_tlast  = 1'b0;
      pop        = 1'b0;
      unique case (state_ff)
         clkd_pkg::BK_CLEAR, clkd_pkg::BK_LOOKUP: begin
         end
         clkd_pkg::BK_IDLE: begin
            pop = item_valid;
         end
         clkd_pkg::BK_REPLY: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = !two_ff;
            pop        = rsp_tready && !two_ff && item_valid;
         end
         clkd_pkg::BK_SECOND: begin
            rsp_tvalid = 1'b1;
            rsp_kind   = kind1_ff;
            rsp_status = clkd_pkg::STAT_OK;
            dest       = (kind1_ff == clkd_pkg::KIND_RETRY) ? waiter_q : dest1_ff;
            rsp_tlast  = 1'b1;
            pop        = rsp_tready && item_valid;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.pop      = pop;
   assign ctrl.clearing = (state_ff == clkd_pkg::BK_CLEAR);

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {{PAD_W{1'b0}}, item_ff.lock_id, dest, rsp_status};

   // Lock record decision
   assign rec       = rec_type'(rec_rd_data);
   assign slot_sum  = SUM_W'(rec.head) + SUM_W'(rec.count);
   assign slot      = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      QIDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(slot_sum);
   assign head_next = (rec.head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rec.head + 1'b1;
   assign lock_base = WADDR_W'(lock_ff) * WADDR_W'(QUEUE_DEPTH);
   assign wq_waddr  = lock_base + WADDR_W'(slot);
   assign wq_raddr  = lock_base + WADDR_W'(rec.head);

   always_comb begin
      new_rec  = rec;
      st0_in   = st0_ff;
      two_in   = two_ff;
      kind1_in = kind1_ff;
      dest1_in = dest1_ff;
      patch_in = 1'b0;
      wq_we    = 1'b0;
      wq_re    = 1'b0;
      if (state_ff == clkd_pkg::BK_LOOKUP) begin
         two_in   = 1'b0;
         kind1_in = clkd_pkg::KIND_REVOKE;
         dest1_in = item_ff.client;
         if (item_ff.cmd == clkd_pkg::CMD_ACQUIRE) begin
            priority if (rec.owner_valid && rec.owner_client == item_ff.client) begin
               st0_in = clkd_pkg::STAT_ALREADY;
            end else if (!rec.owner_valid &&
                         ((rec.count == '0 && !rec.expected_valid) ||
                          (rec.expected_valid && rec.expected_client == item_ff.client)))
            begin
               // Grant; revoke the new owner at once if others wait
               new_rec.owner_valid     = 1'b1;
               new_rec.owner_client    = item_ff.client;
               new_rec.expected_valid  = 1'b0;
               new_rec.expected_client = '0;
               new_rec.revoke_sent     = (rec.count != '0);
               st0_in = clkd_pkg::STAT_OK;
               two_in = (rec.count != '0);
            end else if (rec.count >= CNT_W'(QUEUE_DEPTH)) begin
               st0_in = clkd_pkg::STAT_FULL;
            end else begin
               wq_we         = 1'b1;
               new_rec.count = rec.count + 1'b1;
               st0_in        = clkd_pkg::STAT_RETRY;
               if (rec.owner_valid && !rec.revoke_sent) begin
                  new_rec.revoke_sent = 1'b1;
                  two_in   = 1'b1;
                  dest1_in = rec.owner_client;
               end
            end
         end else begin
            if (!rec.owner_valid || rec.owner_client != item_ff.client) begin
               st0_in = clkd_pkg::STAT_NOT_OWNER;
            end else begin
               new_rec.owner_valid  = 1'b0;
               new_rec.owner_client = '0;
               st0_in = clkd_pkg::STAT_OK;
               if (rec.count != '0) begin
                  // Pop the front waiter; its id arrives through the registered waiter read
                  wq_re                  = 1'b1;
                  patch_in               = 1'b1;
                  new_rec.head           = head_next;
                  new_rec.count          = rec.count - 1'b1;
                  new_rec.expected_valid = 1'b1;
                  two_in   = 1'b1;
                  kind1_in = clkd_pkg::KIND_RETRY;
               end
            end
         end
      end
   end

   always_comb begin
      patch_rec                 = patch_rec_ff;
      patch_rec.expected_client = waiter_q;
   end

   // Record write port: clearing pass, decision, expected-retrier patch
   always_comb begin
      rec_we    = 1'b0;
      rec_waddr = lock_ff;
      rec_wdata = new_rec;
      if (state_ff == clkd_pkg::BK_CLEAR) begin
         rec_we    = 1'b1;
         rec_waddr = clr_idx_ff;
         rec_wdata = '0;
      end else if (state_ff == clkd_pkg::BK_LOOKUP) begin
         rec_we = 1'b1;
      end else if (patch_ff) begin
         rec_we    = 1'b1;
         rec_wdata = patch_rec;
      end
   end

   assign clr_idx_in = (state_ff == clkd_pkg::BK_CLEAR) ? clr_idx_ff + 1'b1 : clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= clkd_pkg::BK_CLEAR;
         clr_idx_ff <= '0;
         patch_ff   <= 1'b0;
         two_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         patch_ff   <= patch_in;
         two_ff     <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= item;
         lock_ff <= item_lock;
      end
      st0_ff   <= st0_in;
      kind1_ff <= kind1_in;
      dest1_ff <= dest1_in;
      if (state_ff == clkd_pkg::BK_LOOKUP) begin
         patch_rec_ff <= new_rec;
      end
   end

endmodule

### sv/caching_lock_directory_core.sv
// Top level of the caching lock directory: front end, back end, checks.
//
//   Channel  Dir  Handshake            Payload
//   req_*    in   tvalid/tready        tuser = cmd, tdata = lock_id, client_id
//   rsp_*    out  tvalid/tready/tlast  tuser = msg_kind, tdata = status,
//                                      dest_client, msg_lock; tlast = last
//
// Per item: a decision state, then one state per response beat; while the next
// item waits, its record read overlaps the last beat. An idle back end first pops
// the item in a state of its own before the decision.
// Reset: synchronous, active high; a clearing pass then frees all NUM_LOCKS
// records, one per cycle, with req_tready held low.
// Stalls: a two-entry queue absorbs rsp_tready stalls; req_tready drops when it is full.
module caching_lock_directory_core #(
   parameter int NUM_LOCKS   = clkd_pkg::DEF_NUM_LOCKS,
   parameter int NUM_CLIENTS = clkd_pkg::DEF_NUM_CLIENTS,
   parameter int QUEUE_DEPTH = clkd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] lock_id, [9:6] client_id, [15:10] zero
   input  logic [clkd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [6:3] dest_client, [12:7] msg_lock, [15:13] zero
   output logic [clkd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] msg_kind
   output logic [clkd_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

   clkd_pkg::back_ctrl_type ctrl;
   clkd_pkg::item_type      item;
   logic                    item_valid;
   logic [LOCK_W-1:0]       item_lock;

   // Accept and classify requests
   clkd_front #(
      .NUM_LOCKS   (NUM_LOCKS),
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctrl       (ctrl),
      .item_valid (item_valid),
      .item       (item),
      .item_lock  (item_lock)
   );

   // Execute against the lock records and emit response beats
   clkd_back #(
      .NUM_LOCKS   (NUM_LOCKS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_lock  (item_lock),
      .ctrl       (ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The second beat of an item follows its first without a gap
   a_second_beat_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second response beat missing");

   // Revoke and retry beats always close an item
   a_notice_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != clkd_pkg::KIND_REPLY) |-> rsp_tlast)
      else $error("revoke or retry beat not last");

   // Refusals cause no second beat
   a_refusal_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == clkd_pkg::KIND_REPLY) &&
      ((rsp_tdata[clkd_pkg::STATUS_W-1:0] == clkd_pkg::STAT_NOT_OWNER) ||
       (rsp_tdata[clkd_pkg::STATUS_W-1:0] == clkd_pkg::STAT_ALREADY) ||
       (rsp_tdata[clkd_pkg::STATUS_W-1:0] == clkd_pkg::STAT_FULL)) |-> rsp_tlast)
      else $error("refusal reply followed by another beat");

   // No request is taken while the records are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock)
      ctrl.clearing |-> !req_tready)
      else $error("request accepted during clearing pass");

endmodule

### bench/lock_dir_checker.sv
// Lock directory checker: mirrors the directory state, predicts response beats, compares them.
module lock_dir_checker
   import clkd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     errors,
   output int                     pending,
   output int                     n_requests,
   output int                     n_beats,
   output int                     n_revokes,
   output int                     n_retries,
   output int                     n_full
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOCKS       = DEF_NUM_LOCKS;
   localparam int CLIENTS     = DEF_NUM_CLIENTS;
   localparam int DEPTH       = DEF_QUEUE_DEPTH;
   localparam int MAX_REPORTS = 40;
   localparam int OWE_DEPTH   = 64;

   typedef struct packed {
      kind_type              kind;
      status_type            status;
      logic [CLIENT_W-1:0]   dest;
      logic [LOCK_ID_W-1:0]  lock_id;
      logic                  last;
   } dir_msg_type;

   // Mirror of the per-lock records and wait lists
   logic                held [LOCKS];
   logic [CLIENT_W-1:0] holder [LOCKS];
   logic                awaited [LOCKS];
   logic [CLIENT_W-1:0] awaited_client [LOCKS];
   logic                revoked [LOCKS];
   logic [CLIENT_W-1:0] waitlist [LOCKS][DEPTH];
   int unsigned         wl_head [LOCKS];
   int unsigned         wl_count [LOCKS];

   // Beats still owed, in order: a ring with free-running indexes
   dir_msg_type         owed_buf [OWE_DEPTH];
   int unsigned         owe_wr;
   int unsigned         owe_rd;

   function automatic dir_msg_type make_msg(kind_type kind, status_type status,
                                            logic [CLIENT_W-1:0] dest,
                                            logic [LOCK_ID_W-1:0] lock_id);
      dir_msg_type m;
      m.kind    = kind;
      m.status  = status;
      m.dest    = dest;
      m.lock_id = lock_id;
      m.last    = 1'b0;
      return m;
   endfunction

   // Append one owed beat to the ring
   task automatic owe_beat(input dir_msg_type m);
      if (owe_wr - owe_rd >= OWE_DEPTH) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: owed beats overflow: expected at most %0d, got %0d",
                     $time, OWE_DEPTH, owe_wr - owe_rd + 1);
      end else begin
         owed_buf[owe_wr % OWE_DEPTH] = m;
         owe_wr++;
      end
   endtask

   // Apply one request to the mirror and queue the beats it owes
   task automatic resolve_request(input cmd_type cmd, input logic [LOCK_ID_W-1:0] lock_in,
                                  input logic [CLIENT_W-1:0] client_in);
      int unsigned         l;
      logic [CLIENT_W-1:0] c;
      int unsigned         slot;
      dir_msg_type         msgs [2];
      int                  n;
      l = lock_in % LOCKS;
      c = CLIENT_W'(client_in % CLIENTS);
      n = 0;
      if (cmd == CMD_ACQUIRE) begin
         if (held[l] && holder[l] == c) begin
            msgs[n++] = make_msg(KIND_REPLY, STAT_ALREADY, c, lock_in);
         end else if (!held[l] && ((wl_count[l] == 0 && !awaited[l]) ||
                                   (awaited[l] && awaited_client[l] == c))) begin
            held[l]           = 1'b1;
            holder[l]         = c;
            awaited[l]        = 1'b0;
            awaited_client[l] = '0;
            revoked[l]        = 1'b0;
            msgs[n++] = make_msg(KIND_REPLY, STAT_OK, c, lock_in);
            if (wl_count[l] > 0) begin
               revoked[l] = 1'b1;
               msgs[n++] = make_msg(KIND_REVOKE, STAT_OK, c, lock_in);
            end
         end else if (wl_count[l] >= DEPTH) begin
            msgs[n++] = make_msg(KIND_REPLY, STAT_FULL, c, lock_in);
         end else begin
            slot = (wl_head[l] + wl_count[l]) % DEPTH;
            waitlist[l][slot] = c;
            wl_count[l]++;
            msgs[n++] = make_msg(KIND_REPLY, STAT_RETRY, c, lock_in);
            if (held[l] && !revoked[l]) begin
               revoked[l] = 1'b1;
               msgs[n++] = make_msg(KIND_REVOKE, STAT_OK, holder[l], lock_in);
            end
         end
      end else begin
         if (!held[l] || holder[l] != c) begin
            msgs[n++] = make_msg(KIND_REPLY, STAT_NOT_OWNER, c, lock_in);
         end else begin
            held[l]   = 1'b0;
            holder[l] = '0;
            msgs[n++] = make_msg(KIND_REPLY, STAT_OK, c, lock_in);
            if (wl_count[l] > 0) begin
               // pop the front waiter; it becomes the one retry we let in
               awaited[l]        = 1'b1;
               awaited_client[l] = waitlist[l][wl_head[l]];
               wl_head[l]        = (wl_head[l] + 1) % DEPTH;
               wl_count[l]--;
               msgs[n++] = make_msg(KIND_RETRY, STAT_OK, awaited_client[l], lock_in);
            end
         end
      end
      msgs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (msgs[i].kind == KIND_REVOKE) n_revokes++;
         if (msgs[i].kind == KIND_RETRY) n_retries++;
         if (msgs[i].kind == KIND_REPLY && msgs[i].status == STAT_FULL) n_full++;
         owe_beat(msgs[i]);
      end
   endtask

   task automatic compare_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   task automatic check_beat();
      dir_msg_type want;
      dir_msg_type got;
      got.kind    = kind_type'(rsp_tuser);
      got.status  = status_type'(rsp_tdata[STATUS_W-1:0]);
      got.dest    = rsp_tdata[STATUS_W +: CLIENT_W];
      got.lock_id = rsp_tdata[STATUS_W+CLIENT_W +: LOCK_ID_W];
      got.last    = rsp_tlast;
      n_beats++;
      if (owe_wr == owe_rd) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: unexpected beat: expected none, %s %0d %0d %0d %0d",
                     $time, "got kind/status/dest/lock",
                     got.kind, got.status, got.dest, got.lock_id);
      end else begin
         want = owed_buf[owe_rd % OWE_DEPTH];
         owe_rd++;
         compare_field("msg_kind", want.kind, got.kind);
         compare_field("status", want.status, got.status);
         compare_field("dest_client", want.dest, got.dest);
         compare_field("msg_lock", want.lock_id, got.lock_id);
         compare_field("last", want.last, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LOCKS; l++) begin
            held[l]           = 1'b0;
            holder[l]         = '0;
            awaited[l]        = 1'b0;
            awaited_client[l] = '0;
            revoked[l]        = 1'b0;
            wl_head[l]        = 0;
            wl_count[l]       = 0;
         end
         owe_wr = 0;
         owe_rd = 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready) begin
            n_requests++;
            resolve_request(cmd_type'(req_tuser), req_tdata[LOCK_ID_W-1:0],
                            req_tdata[LOCK_ID_W +: CLIENT_W]);
         end
         pending <= int'(owe_wr - owe_rd);
      end
   end

endmodule

### bench/tb.sv
// Testbench top: bursty request traffic, stalled responses, and the final verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import clkd_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int TAIL_CYCLES  = 20;

   // Receiver behavior, switched after a random phase length
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_PATTERN,
      RX_CHOKE
   } rx_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [5:0] lock_id, [9:6] client_id, [15:10] zero
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [0] cmd
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [2:0] status, [6:3] dest_client, [12:7] msg_lock, [15:13] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] msg_kind
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   int errors;
   int pending;
   int n_requests;
   int n_beats;
   int n_revokes;
   int n_retries;
   int n_full;

   int burst_left = 0;
   int cycles     = 0;

   always #5 clock = ~clock;

   caching_lock_directory_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lock_dir_checker audit (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending),
      .n_requests (n_requests),
      .n_beats    (n_beats),
      .n_revokes  (n_revokes),
      .n_retries  (n_retries),
      .n_full     (n_full)
   );

   // Hard stop: covers the clearing pass, slow stalls and the drain at the end
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles, %0d beats still owed", cycles, pending);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Response side: open, a rotating 8-bit pattern, or heavy random choking.
   // The phase length is random so stalls drift across the block's cycles.
   rx_mode_type rx_mode    = RX_OPEN;
   logic [7:0]  rx_pattern = 8'hff;
   logic [2:0]  rx_idx     = '0;
   int          rx_left    = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode    <= rx_mode_type'($urandom_range(0, 2));
         rx_pattern <= 8'($urandom) | 8'h01;
         rx_left    <= $urandom_range(16, 96);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_idx <= rx_idx + 3'd1;
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_PATTERN: begin
            rsp_tready <= rx_pattern[rx_idx];
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // Drive one request beat and hold it until the block takes it.
   // Between bursts, drop valid first for a random gap that may be empty; inside a burst,
   // keep valid high and just swap the payload at the falling edge.
   task automatic send_beat(input cmd_type cmd, input logic [LOCK_ID_W-1:0] lock_id,
                            input logic [CLIENT_W-1:0] client);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 9);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'({client, lock_id});
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int unsigned          acquire_pct;
      int unsigned          hot_lock;
      int unsigned          hot_client;
      int unsigned          pick;
      logic [LOCK_ID_W-1:0] lock_id;
      logic [CLIENT_W-1:0]  client;
      cmd_type              cmd;
      int                   directed;

      acquire_pct = 50;
      hot_lock    = 0;
      hot_client  = 0;

      // Hold reset, then release it; the block then clears its records on its own
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: extreme indices, re-acquire by the owner, release by a
      // stranger and of a free lock
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(LOCK_ID_SPAN - 1), CLIENT_W'(CLIENT_SPAN - 1));
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(LOCK_ID_SPAN - 1), CLIENT_W'(CLIENT_SPAN - 1));
      send_beat(CMD_RELEASE, LOCK_ID_W'(LOCK_ID_SPAN - 1), CLIENT_W'(0));
      send_beat(CMD_RELEASE, LOCK_ID_W'(0), CLIENT_W'(0));

      // Own lock 0, then fill its wait list with duplicates; the first waiter
      // triggers the single revoke, the one after a full list is turned away
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(0), CLIENT_W'(1));
      for (int k = 0; k < DEF_QUEUE_DEPTH; k++)
         send_beat(CMD_ACQUIRE, LOCK_ID_W'(0), CLIENT_W'(2 + (k % 14)));
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(0), CLIENT_W'(9));

      // Owner lets go: front waiter gets the retry. A stranger arriving while
      // that retry is pending gets queued without a revoke, then the expected
      // client takes the lock and is revoked at once since others still wait.
      send_beat(CMD_RELEASE, LOCK_ID_W'(0), CLIENT_W'(1));
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(0), CLIENT_W'(5));
      send_beat(CMD_ACQUIRE, LOCK_ID_W'(0), CLIENT_W'(2));
      send_beat(CMD_RELEASE, LOCK_ID_W'(LOCK_ID_SPAN - 1), CLIENT_W'(CLIENT_SPAN - 1));
      // Let the checker count the last accept before reading its total
      #1 directed = n_requests;

      // Random: traffic concentrated on a few hot locks and clients so queues
      // build, drain, and expected retriers come back; every hundred items the mix
      // is picked at random as an acquire-heavy or a release-heavy stretch.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            acquire_pct = ($urandom_range(0, 1) == 0) ? 75 : 30;
            hot_lock    = $urandom_range(0, LOCK_ID_SPAN - 4);
            hot_client  = $urandom_range(0, CLIENT_SPAN - 4);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70)
            lock_id = LOCK_ID_W'(hot_lock + $urandom_range(0, 3));
         else if (pick < 78)
            lock_id = ($urandom_range(0, 1) == 0) ? '0 : '1;
         else
            lock_id = LOCK_ID_W'($urandom_range(0, LOCK_ID_SPAN - 1));
         if ($urandom_range(0, 99) < 75)
            client = CLIENT_W'(hot_client + $urandom_range(0, 3));
         else
            client = CLIENT_W'($urandom_range(0, CLIENT_SPAN - 1));
         cmd = ($urandom_range(0, 99) < acquire_pct) ? CMD_ACQUIRE : CMD_RELEASE;
         send_beat(cmd, lock_id, client);
      end
      @(negedge clock) req_tvalid <= 1'b0;

      // Drain: wait for every owed beat, then wait out a tail for strays
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d requests (%0d directed, rest random), %0d response beats checked",
               n_requests, directed, n_beats);
      $display("tb: %0d revokes, %0d retries to waiters, %0d queue-full replies",
               n_revokes, n_retries, n_full);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", errors);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
